// ----- src/fbpa_pkg.sv -----
// shared constants, codes and structs for the fixed block pool allocator
// no dependencies; imported by every module and interface of the block
package fbpa_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int PTR_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = PTR_W + 1;
    localparam int IDX_W      = 8;
    localparam int TOTAL_W    = 32;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK          = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_RANGE       = 2'd3
    } status_t;

    // one decided operation, shared by ring and tracking logic
    typedef struct packed
    {
        logic             alloc_ok;
        logic             free_ok;
        logic [IDX_W-1:0] grant_idx;
        logic [IDX_W-1:0] free_idx;
    } cmd_t;

    // counters as they stand after the current operation
    typedef struct packed
    {
        logic [CNT_W-1:0]   used;
        logic [CNT_W-1:0]   peak;
        logic [TOTAL_W-1:0] alloc_total;
        logic [TOTAL_W-1:0] free_total;
    } stats_t;

endpackage

// ----- src/fbpa_req_if.sv -----
// request channel of the pool allocator: operation and block index
// depends on fbpa_pkg
interface fbpa_req_if
    import fbpa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, operation, block_index, input ready);
    modport sink   (input valid, operation, block_index, output ready);
endinterface

// ----- src/fbpa_rsp_if.sv -----
// result channel of the pool allocator: grant, status and counters
// depends on fbpa_pkg
interface fbpa_rsp_if
    import fbpa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   granted_index;
    logic [1:0]         status;
    logic [CNT_W-1:0]   blocks_in_use;
    logic [CNT_W-1:0]   peak_in_use;
    logic [CNT_W-1:0]   free_blocks;
    logic [TOTAL_W-1:0] alloc_total;
    logic [TOTAL_W-1:0] free_total;

    modport source (output valid, granted_index, status, blocks_in_use, peak_in_use,
                    free_blocks, alloc_total, free_total, input ready);
    modport sink   (input valid, granted_index, status, blocks_in_use, peak_in_use,
                    free_blocks, alloc_total, free_total, output ready);
endinterface

// ----- src/fbpa_ring.sv -----
// free list ring: index memory, head and tail pointers, fill count
// depends on fbpa_pkg; entries not written since the last fill read as their own address
module fbpa_ring
    import fbpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fill,
    input  logic [CNT_W-1:0] fill_count,
    input  cmd_t             cmd,
    output logic [CNT_W-1:0] ring_fill,
    output logic [CNT_W-1:0] ring_fill_next,
    output logic [IDX_W-1:0] head_word
);

    logic [IDX_W-1:0]      mem [MAX_BLOCKS];
    logic [IDX_W-1:0]      mem_q_reg;
    logic [MAX_BLOCKS-1:0] written_reg;
    logic [PTR_W-1:0]      head_reg;
    logic [PTR_W-1:0]      head_next;
    logic [PTR_W-1:0]      tail_reg;
    logic [PTR_W-1:0]      tail_next;
    logic [CNT_W-1:0]      fill_reg;
    logic                  byp_reg;
    logic                  byp_next;
    logic [IDX_W-1:0]      byp_data_reg;
    logic                  vld_reg;
    logic                  vld_next;
    logic                  push;

    assign push = cmd.free_ok && !fill;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        ring_fill_next = fill_reg;
        if (fill)
        begin
            head_next      = '0;
            tail_next      = fill_count[PTR_W-1:0];
            ring_fill_next = fill_count;
        end
        else if (cmd.alloc_ok)
        begin
            head_next      = head_reg + PTR_W'(1);
            ring_fill_next = fill_reg - CNT_W'(1);
        end
        else if (cmd.free_ok)
        begin
            tail_next      = tail_reg + PTR_W'(1);
            ring_fill_next = fill_reg + CNT_W'(1);
        end
    end

    // a write landing on the next head address is forwarded around the memory
    assign byp_next = push && (tail_reg == head_next);
    assign vld_next = !fill && written_reg[head_next];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= cmd.free_idx;
        end
        mem_q_reg    <= mem[head_next];
        byp_data_reg <= cmd.free_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= PTR_W'(MAX_BLOCKS);
            fill_reg    <= CNT_W'(MAX_BLOCKS);
            written_reg <= '0;
            byp_reg     <= 1'b0;
            vld_reg     <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= ring_fill_next;
            byp_reg  <= byp_next;
            vld_reg  <= vld_next;
            if (fill)
            begin
                written_reg <= '0;
            end
            else if (push)
            begin
                written_reg[tail_reg] <= 1'b1;
            end
        end
    end

    assign ring_fill = fill_reg;
    assign head_word = byp_reg ? byp_data_reg :
                       vld_reg ? mem_q_reg    : IDX_W'(head_reg);

endmodule

// ----- src/fbpa_track.sv -----
// in-use flags per block plus in-use, peak and transfer total counters
// depends on fbpa_pkg
module fbpa_track
    import fbpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fill,
    input  cmd_t             cmd,
    input  logic [IDX_W-1:0] query_idx,
    output logic             query_in_use,
    output stats_t           stats,
    output stats_t           stats_next
);

    logic [MAX_BLOCKS-1:0] in_use_reg;
    stats_t                stats_reg;

    assign query_in_use = in_use_reg[query_idx[PTR_W-1:0]];

    always_comb
    begin
        stats_next = stats_reg;
        if (fill)
        begin
            stats_next = '0;
        end
        else if (cmd.alloc_ok)
        begin
            stats_next.used        = stats_reg.used + CNT_W'(1);
            stats_next.alloc_total = stats_reg.alloc_total + TOTAL_W'(1);
            if (stats_next.used > stats_reg.peak)
            begin
                stats_next.peak = stats_next.used;
            end
        end
        else if (cmd.free_ok)
        begin
            if (stats_reg.used != '0)
            begin
                stats_next.used = stats_reg.used - CNT_W'(1);
            end
            stats_next.free_total = stats_reg.free_total + TOTAL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            stats_reg  <= '0;
        end
        else
        begin
            stats_reg <= stats_next;
            if (fill)
            begin
                in_use_reg <= '0;
            end
            else if (cmd.alloc_ok)
            begin
                in_use_reg[cmd.grant_idx[PTR_W-1:0]] <= 1'b1;
            end
            else if (cmd.free_ok)
            begin
                in_use_reg[cmd.free_idx[PTR_W-1:0]] <= 1'b0;
            end
        end
    end

    assign stats = stats_reg;

endmodule

// ----- src/fixed_block_pool_allocator.sv -----
// fixed block pool allocator: request register, one pass of decision logic, result register
// an accepted request is held in the request register and decided; its result is captured in the result register on rsp
// throughput: one request per cycle unless rsp stalls; registered ring read prefetched at next head
// reset and any block_count write refill the free list with 0 .. block_count-1 at once
// depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if, fbpa_ring, fbpa_track
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,
    fbpa_req_if.sink          req,
    fbpa_rsp_if.source        rsp
);

    logic             in_valid_reg;
    logic             in_op_reg;
    logic [IDX_W-1:0] in_idx_reg;
    logic [CNT_W-1:0] block_count_reg;
    logic [CNT_W-1:0] block_count_next;
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_grant_reg;
    status_t          out_status_reg;
    logic [CNT_W-1:0] out_fill_reg;
    stats_t           out_stats_reg;

    logic             out_room;
    logic             take;
    logic             is_alloc;
    logic             idx_bad;
    logic             query_in_use;
    logic [CNT_W-1:0] ring_fill;
    logic [CNT_W-1:0] ring_fill_next;
    logic [IDX_W-1:0] head_word;
    cmd_t             cmd;
    status_t          status_now;
    stats_t           stats;
    stats_t           stats_next;

    // clamp the written pool size into 1 .. MAX_BLOCKS
    always_comb
    begin
        block_count_next = cfg_wdata;
        if (cfg_wdata == '0)
        begin
            block_count_next = CNT_W'(1);
        end
        else if (cfg_wdata > CNT_W'(MAX_BLOCKS))
        begin
            block_count_next = CNT_W'(MAX_BLOCKS);
        end
    end

    assign out_room  = !out_valid_reg || rsp.ready;
    assign take      = in_valid_reg && out_room;
    assign req.ready = !in_valid_reg || out_room;

    assign is_alloc = (op_t'(in_op_reg) == OP_ALLOC);
    assign idx_bad  = {1'b0, in_idx_reg} >= block_count_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.grant_idx  = head_word;
        cmd.free_idx   = in_idx_reg;
        status_now     = ST_OK;
        if (is_alloc)
        begin
            if (ring_fill == '0)
            begin
                status_now = ST_EMPTY;
            end
            else
            begin
                cmd.alloc_ok = take;
            end
        end
        else if (idx_bad)
        begin
            status_now = ST_RANGE;
        end
        else if (!query_in_use)
        begin
            status_now = ST_DOUBLE_FREE;
        end
        else
        begin
            cmd.free_ok = take;
        end
    end

    fbpa_ring u_ring
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fill           (cfg_we),
        .fill_count     (block_count_next),
        .cmd            (cmd),
        .ring_fill      (ring_fill),
        .ring_fill_next (ring_fill_next),
        .head_word      (head_word)
    );

    fbpa_track u_track
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fill         (cfg_we),
        .cmd          (cmd),
        .query_idx    (in_idx_reg),
        .query_in_use (query_in_use),
        .stats        (stats),
        .stats_next   (stats_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            block_count_reg <= CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            if (cfg_we)
            begin
                block_count_reg <= block_count_next;
            end
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (out_room)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_op_reg  <= req.operation;
            in_idx_reg <= req.block_index;
        end
        if (take)
        begin
            out_grant_reg  <= cmd.alloc_ok ? head_word : '0;
            out_status_reg <= status_now;
            out_fill_reg   <= ring_fill_next;
            out_stats_reg  <= stats_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_index = out_grant_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.blocks_in_use = out_stats_reg.used;
    assign rsp.peak_in_use   = out_stats_reg.peak;
    assign rsp.free_blocks   = out_fill_reg;
    assign rsp.alloc_total   = out_stats_reg.alloc_total;
    assign rsp.free_total    = out_stats_reg.free_total;

    // every block is either on the free list or counted as in use
    a_pool_conserved: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, ring_fill} + {1'b0, stats.used}) == {1'b0, block_count_reg})
        else $error("free list and in-use count do not add up to the pool size");

    // an index handed out always lies inside the pool
    a_grant_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_ok |-> ({1'b0, head_word} < block_count_reg))
        else $error("granted index outside the pool");

    // peak never trails the live in-use count
    a_peak_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        stats.peak >= stats.used)
        else $error("peak in-use count below current in-use count");

    // the decision never overwrites the result register while it is blocked
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> $stable(out_status_reg) && $stable(out_fill_reg))
        else $error("result overwritten while stalled");

endmodule
